FILE: rtl/core/encoder_homing_calibrator_assert.svh
// ----------------------------------------------------------------------------
// Encoder homing calibrator assertion macros
// Implication checks sampled on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ENCODER_HOMING_CALIBRATOR_ASSERT_SVH
`define ENCODER_HOMING_CALIBRATOR_ASSERT_SVH

// Same-cycle implication.
`define EHC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define EHC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/ehc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehc_pkg
// Types and constants of the encoder homing calibrator.
// ----------------------------------------------------------------------------
package ehc_pkg;

  localparam int unsigned PosW   = 32;
  localparam int unsigned DriveW = 9;
  localparam int unsigned TimeW  = 16;
  localparam int unsigned CprW   = 16;
  localparam int unsigned RatioW = 32;
  localparam int unsigned FracW  = 16;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 2;

  // One quotient bit per step over the dividend |pos| << 16
  localparam int unsigned DivSteps = PosW + FracW;
  localparam int unsigned DivCntW  = $clog2(DivSteps + 1);

  localparam logic [DriveW-1:0] SeekSpeedRst = 9'd64;
  localparam logic [TimeW-1:0]  TimeoutRst   = 16'd30000;
  localparam logic [CprW-1:0]   CprRst       = 16'd600;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SEEK = 2'd1,
    PH_ROT  = 2'd2,
    PH_DONE = 2'd3
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SEEK_SPEED     = 2'd0,
    CFG_TIMEOUT_MS     = 2'd1,
    CFG_COUNTS_PER_REV = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_DIV  = 1'b1
  } ctl_state_e;

endpackage

FILE: rtl/core/encoder_homing_calibrator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_homing_calibrator
// Position counter, home latch, phase timer and homing sequencer with a
// bit-serial Q16.16 gear ratio divider.
// ----------------------------------------------------------------------------
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid_i/in_ready_o, event bits    | request in
//  out     | out_valid_o/out_ready_i, status      | request out
//  cfg     | cfg_we_i, cfg_idx_i, cfg_data_i      | write only
//
//  Unless it completes calibration, a request's status is valid the cycle
//  after it is taken. A request that completes calibration waits for the
//  restoring divider: one quotient bit per cycle over |count| << 16.
//  A new request is taken while the last status is taken in the same cycle.
//  Reset puts the sequencer in idle, clears the count, timer and ratio and
//  loads the register defaults (64, 30000, 600).
// ----------------------------------------------------------------------------
module encoder_homing_calibrator
  import ehc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i,

  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                start_req_i,
  input  logic                enc_a_rise_i,
  input  logic                enc_b_level_i,
  input  logic                home_fall_i,
  input  logic                ms_tick_i,

  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          phase_o,
  output logic signed [DriveW-1:0] motor_drive_o,
  output logic signed [PosW-1:0]   position_count_o,
  output logic [RatioW-1:0]   gear_ratio_o,
  output logic                calibrating_o,
  output logic                timed_out_o,
  output logic                finished_o
);

  localparam logic [DivCntW-1:0] DivLoad  = DivCntW'(DivSteps);
  localparam logic [DivCntW-1:0] MagSteps = DivCntW'(DivSteps - PosW);

  // configuration
  logic [DriveW-1:0] seek_speed_q;
  logic [TimeW-1:0]  timeout_q;
  logic [CprW-1:0]   cpr_q;

  // architectural state
  phase_e            phase_q, phase_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic              home_q, home_d;
  logic [TimeW-1:0]  elapsed_q, elapsed_d;
  logic [RatioW-1:0] ratio_q, ratio_d;
  logic [DriveW-1:0] drive_q, drive_d;
  logic              tout_q, tout_d;
  logic              fin_q, fin_d;

  // control
  ctl_state_e        ctl_q, ctl_d;
  logic              out_valid_q, out_valid_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;

  // divider datapath
  logic [PosW-1:0]   dvd_q, dvd_d;
  logic [CprW-1:0]   rem_q, rem_d;
  logic [RatioW-1:0] quo_q, quo_d;
  logic              ovf_q, ovf_d;

  logic              in_acc;
  logic              div_go;
  logic              in_bit;
  logic [CprW:0]     rem_sh;
  logic [CprW:0]     rem_sub;
  logic              ge;
  logic [RatioW-1:0] quo_nx;
  logic              ovf_nx;

  assign in_ready_o = (ctl_q == CS_IDLE) && (!out_valid_q || out_ready_i);
  assign in_acc     = in_valid_i && in_ready_o;

  // restoring divider step
  assign in_bit  = (cnt_q > MagSteps) ? dvd_q[PosW-1] : 1'b0;
  assign rem_sh  = {rem_q, in_bit};
  assign rem_sub = rem_sh - {1'b0, cpr_q};
  assign ge      = (rem_sh >= {1'b0, cpr_q});
  assign quo_nx  = {quo_q[RatioW-2:0], ge};
  assign ovf_nx  = ovf_q | quo_q[RatioW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seek_speed_q <= SeekSpeedRst;
      timeout_q    <= TimeoutRst;
      cpr_q        <= CprRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SEEK_SPEED:     seek_speed_q <= cfg_data_i[DriveW-1:0];
        CFG_TIMEOUT_MS:     timeout_q    <= cfg_data_i[TimeW-1:0];
        CFG_COUNTS_PER_REV: cpr_q        <= cfg_data_i[CprW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q       <= CS_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      phase_q     <= PH_IDLE;
      pos_q       <= '0;
      home_q      <= 1'b0;
      elapsed_q   <= '0;
      ratio_q     <= '0;
      drive_q     <= '0;
      tout_q      <= 1'b0;
      fin_q       <= 1'b0;
    end else begin
      ctl_q       <= ctl_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      home_q      <= home_d;
      elapsed_q   <= elapsed_d;
      ratio_q     <= ratio_d;
      drive_q     <= drive_d;
      tout_q      <= tout_d;
      fin_q       <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    ovf_q <= ovf_d;
  end

  always_comb begin
    ctl_d       = ctl_q;
    out_valid_d = out_valid_q;
    cnt_d       = cnt_q;
    phase_d     = phase_q;
    pos_d       = pos_q;
    home_d      = home_q;
    elapsed_d   = elapsed_q;
    ratio_d     = ratio_q;
    drive_d     = drive_q;
    tout_d      = tout_q;
    fin_d       = fin_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    ovf_d       = ovf_q;
    div_go      = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (ctl_q)
      CS_IDLE: begin
        if (in_acc) begin
          tout_d = 1'b0;
          fin_d  = 1'b0;
          if (start_req_i && (phase_q == PH_IDLE)) begin
            home_d    = 1'b0;
            phase_d   = PH_SEEK;
            elapsed_d = '0;
            drive_d   = seek_speed_q;
          end
          if (enc_a_rise_i) begin
            pos_d = enc_b_level_i ? (pos_q - 1'b1) : (pos_q + 1'b1);
          end
          if (home_fall_i) begin
            home_d = 1'b1;
          end
          if (ms_tick_i && (elapsed_d != '1)) begin
            elapsed_d = elapsed_d + 1'b1;
          end
          case (phase_d)
            PH_SEEK, PH_ROT: begin
              if (elapsed_d >= timeout_q) begin
                drive_d = '0;
                phase_d = PH_IDLE;
                tout_d  = 1'b1;
              end else if (home_d) begin
                home_d = 1'b0;
                if (phase_d == PH_SEEK) begin
                  pos_d     = '0;
                  elapsed_d = '0;
                  phase_d   = PH_ROT;
                end else begin
                  div_go  = 1'b1;
                  phase_d = PH_DONE;
                  fin_d   = 1'b1;
                end
              end
            end
            PH_DONE: begin
              drive_d = '0;
              phase_d = PH_IDLE;
            end
            default: ;
          endcase
          if (div_go) begin
            // hold the status back until the ratio is in
            dvd_d = pos_d[PosW-1] ? (PosW'(0) - pos_d) : pos_d;
            rem_d = '0;
            quo_d = '0;
            ovf_d = 1'b0;
            cnt_d = DivLoad;
            ctl_d = CS_DIV;
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      CS_DIV: begin
        dvd_d = {dvd_q[PosW-2:0], 1'b0};
        rem_d = ge ? rem_sub[CprW-1:0] : rem_sh[CprW-1:0];
        quo_d = quo_nx;
        ovf_d = ovf_nx;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == DivCntW'(1)) begin
          // saturate when the quotient spilled past 32 bits
          ratio_d     = ovf_nx ? '1 : quo_nx;
          out_valid_d = 1'b1;
          ctl_d       = CS_IDLE;
        end
      end
      default: begin
        ctl_d = CS_IDLE;
      end
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign phase_o          = phase_q;
  assign motor_drive_o    = drive_q;
  assign position_count_o = pos_q;
  assign gear_ratio_o     = ratio_q;
  assign calibrating_o    = (phase_q != PH_IDLE);
  assign timed_out_o      = tout_q;
  assign finished_o       = fin_q;

`include "encoder_homing_calibrator_assert.svh"

  `EHC_ASSERT_SAME(a_fin_done, out_valid_o && finished_o, phase_o == PH_DONE, "finish without done")
  `EHC_ASSERT_SAME(a_tout_stop, out_valid_o && timed_out_o, (phase_o == PH_IDLE) && (motor_drive_o == '0), "timeout left motor running")
  `EHC_ASSERT_NEXT(a_div_block, in_acc && div_go, !in_ready_o && !out_valid_o, "request taken during divide")
  `EHC_ASSERT_SAME(a_div_phase, ctl_q == CS_DIV, (phase_q == PH_DONE) && fin_q && !out_valid_q, "divide outside done phase")

endmodule
